/* design/hbc_pkg.sv */
// hbc_pkg: shared types and constants of the hashed block buffer cache
// no dependencies; used by every module under design/
package hbc_pkg;

    localparam int DEV_W  = 32;
    localparam int BLK_W  = 32;
    localparam int CNT_W  = 6;
    localparam int SLOT_W = 5;
    localparam int OP_W   = 2;
    localparam int STAT_W = 2;

    localparam logic [CNT_W-1:0] CNT_MAX = 6'd63;

    localparam int BUFFER_COUNT_DEF = 32;
    localparam int BUCKET_COUNT_DEF = 13;

    localparam logic [OP_W-1:0] OP_GET     = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_PIN     = 2'd2;
    localparam logic [OP_W-1:0] OP_UNPIN   = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_BUFFER = 2'd1;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic [DEV_W-1:0] dev;
        logic [BLK_W-1:0] blk;
        logic [CNT_W-1:0] cnt;
        logic             dval;
    } entry_t;

    typedef struct packed {
        logic   we;
        entry_t data;
    } entry_wr_t;

endpackage

/* design/hbc_entry_mem.sv */
// hbc_entry_mem: per-buffer tag, count and valid record memory
// registered synchronous read; depends on hbc_pkg
module hbc_entry_mem #(
    parameter int BUFFER_COUNT = hbc_pkg::BUFFER_COUNT_DEF,
    parameter int ENT_W = (BUFFER_COUNT > 1) ? $clog2(BUFFER_COUNT) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [ENT_W-1:0]   raddr,
    output hbc_pkg::entry_t    rdata,
    input  hbc_pkg::entry_wr_t wr,
    input  logic [ENT_W-1:0]   waddr
);

    hbc_pkg::entry_t mem [BUFFER_COUNT];
    logic [BUFFER_COUNT-1:0] init_reg;
    hbc_pkg::entry_t rd_reg;
    logic rd_ok_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[waddr] <= wr.data;
        end
        rd_reg <= mem[raddr];
    end

    // entries never written read as the reset record (all zero)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg  <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (wr.we)
            begin
                init_reg[waddr] <= 1'b1;
            end
            rd_ok_reg <= init_reg[raddr];
        end
    end

    assign rdata = rd_ok_reg ? rd_reg : '0;

endmodule

/* design/hbc_link_mem.sv */
// hbc_link_mem: next and prev link memories over entries and bucket heads
// registered synchronous read, reset lists all entries in bucket zero; depends on hbc_pkg
module hbc_link_mem #(
    parameter int BUFFER_COUNT = hbc_pkg::BUFFER_COUNT_DEF,
    parameter int BUCKET_COUNT = hbc_pkg::BUCKET_COUNT_DEF,
    parameter int NODE_COUNT = BUFFER_COUNT + BUCKET_COUNT,
    parameter int NODE_W = $clog2(NODE_COUNT)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [NODE_W-1:0] raddr,
    output logic [NODE_W-1:0] next_rd,
    output logic [NODE_W-1:0] prev_rd,
    input  logic              next_we,
    input  logic [NODE_W-1:0] next_waddr,
    input  logic [NODE_W-1:0] next_wdata,
    input  logic              prev_we,
    input  logic [NODE_W-1:0] prev_waddr,
    input  logic [NODE_W-1:0] prev_wdata
);

    function automatic int next_reset(input int i);
        int r;
        if (i < BUFFER_COUNT)
        begin
            r = (i == 0) ? BUFFER_COUNT : i - 1;
        end
        else if (i == BUFFER_COUNT)
        begin
            r = BUFFER_COUNT - 1;
        end
        else
        begin
            r = i;
        end
        return r;
    endfunction

    function automatic int prev_reset(input int i);
        int r;
        if (i < BUFFER_COUNT)
        begin
            r = (i == BUFFER_COUNT - 1) ? BUFFER_COUNT : i + 1;
        end
        else if (i == BUFFER_COUNT)
        begin
            r = 0;
        end
        else
        begin
            r = i;
        end
        return r;
    endfunction

    logic [NODE_W-1:0] next_mem [NODE_COUNT];
    logic [NODE_W-1:0] prev_mem [NODE_COUNT];
    logic [NODE_COUNT-1:0] next_init_reg;
    logic [NODE_COUNT-1:0] prev_init_reg;
    logic [NODE_W-1:0] next_mem_reg;
    logic [NODE_W-1:0] prev_mem_reg;
    logic [NODE_W-1:0] next_rst_reg;
    logic [NODE_W-1:0] prev_rst_reg;
    logic next_ok_reg;
    logic prev_ok_reg;

    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
        if (prev_we)
        begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        next_mem_reg <= next_mem[raddr];
        prev_mem_reg <= prev_mem[raddr];
        next_rst_reg <= NODE_W'(next_reset(int'(raddr)));
        prev_rst_reg <= NODE_W'(prev_reset(int'(raddr)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_init_reg <= '0;
            prev_init_reg <= '0;
            next_ok_reg   <= 1'b0;
            prev_ok_reg   <= 1'b0;
        end
        else
        begin
            if (next_we)
            begin
                next_init_reg[next_waddr] <= 1'b1;
            end
            if (prev_we)
            begin
                prev_init_reg[prev_waddr] <= 1'b1;
            end
            next_ok_reg <= next_init_reg[raddr];
            prev_ok_reg <= prev_init_reg[raddr];
        end
    end

    assign next_rd = next_ok_reg ? next_mem_reg : next_rst_reg;
    assign prev_rd = prev_ok_reg ? prev_mem_reg : prev_rst_reg;

endmodule

/* design/hbc_ctrl.sv */
// hbc_ctrl: sequencer for get, release, pin and unpin; walks bucket lists
// through the entry and link memories; depends on hbc_pkg
module hbc_ctrl #(
    parameter int BUFFER_COUNT = hbc_pkg::BUFFER_COUNT_DEF,
    parameter int BUCKET_COUNT = hbc_pkg::BUCKET_COUNT_DEF,
    parameter int NODE_W = $clog2(BUFFER_COUNT + BUCKET_COUNT),
    parameter int ENT_W = (BUFFER_COUNT > 1) ? $clog2(BUFFER_COUNT) : 1,
    parameter int BKT_W = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [hbc_pkg::OP_W-1:0]   op,
    input  logic [hbc_pkg::DEV_W-1:0]  device,
    input  logic [hbc_pkg::BLK_W-1:0]  block_number,
    input  logic [hbc_pkg::SLOT_W-1:0] entry_index,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [hbc_pkg::SLOT_W-1:0] buffer_slot,
    output logic                       hit,
    output logic                       needs_fill,
    output logic [hbc_pkg::STAT_W-1:0] status,
    output logic [ENT_W-1:0]           ent_raddr,
    input  hbc_pkg::entry_t            ent_rd,
    output hbc_pkg::entry_wr_t         ent_wr,
    output logic [ENT_W-1:0]           ent_waddr,
    output logic [NODE_W-1:0]          link_raddr,
    input  logic [NODE_W-1:0]          next_rd,
    input  logic [NODE_W-1:0]          prev_rd,
    output logic                       next_we,
    output logic [NODE_W-1:0]          next_waddr,
    output logic [NODE_W-1:0]          next_wdata,
    output logic                       prev_we,
    output logic [NODE_W-1:0]          prev_waddr,
    output logic [NODE_W-1:0]          prev_wdata
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MOD   = 4'd1;
    localparam logic [3:0] S_HWALK = 4'd2;
    localparam logic [3:0] S_SWALK = 4'd3;
    localparam logic [3:0] S_PUSH1 = 4'd4;
    localparam logic [3:0] S_PUSH2 = 4'd5;
    localparam logic [3:0] S_CNT   = 4'd6;
    localparam logic [3:0] S_DONE  = 4'd7;
    localparam logic [3:0] S_QUOT  = 4'd8;
    localparam logic [3:0] S_REM   = 4'd9;

    localparam logic [NODE_W-1:0] HEAD0 = NODE_W'(BUFFER_COUNT);
    localparam logic [BKT_W-1:0]  BKT_LAST = BKT_W'(BUCKET_COUNT - 1);

    // byte weights 2^(8k) mod BUCKET_COUNT; the folded sum stays below 2^15
    localparam int FOLD_W = 15;
    localparam int RECIP_SH = FOLD_W + 5;
    localparam int PROD_W = FOLD_W + RECIP_SH + 1;
    localparam logic [FOLD_W-1:0] W0 = FOLD_W'(1 % BUCKET_COUNT);
    localparam logic [FOLD_W-1:0] W1 = FOLD_W'((1 << 8) % BUCKET_COUNT);
    localparam logic [FOLD_W-1:0] W2 = FOLD_W'((1 << 16) % BUCKET_COUNT);
    localparam logic [FOLD_W-1:0] W3 = FOLD_W'((1 << 24) % BUCKET_COUNT);
    localparam logic [RECIP_SH:0] RECIP =
        (RECIP_SH+1)'(((1 << RECIP_SH) + BUCKET_COUNT - 1) / BUCKET_COUNT);
    localparam logic [FOLD_W-1:0] BKT_MUL = FOLD_W'(BUCKET_COUNT);

    logic [3:0] state_reg, state_next;
    logic [hbc_pkg::OP_W-1:0] op_reg, op_next;
    logic [hbc_pkg::DEV_W-1:0] dev_reg, dev_next;
    logic [hbc_pkg::BLK_W-1:0] blk_reg, blk_next;
    logic [FOLD_W-1:0] fold_reg, fold_next;
    logic [FOLD_W-1:0] quot_reg, quot_next;
    logic [hbc_pkg::SLOT_W-1:0] ent_reg, ent_next;
    logic [BKT_W-1:0] mod_reg, mod_next;
    logic [BKT_W-1:0] bkt_reg, bkt_next;
    logic [NODE_W-1:0] cur_reg, cur_next;
    logic [NODE_W-1:0] victim_reg, victim_next;
    logic [hbc_pkg::SLOT_W-1:0] res_slot_reg, res_slot_next;
    logic res_hit_reg, res_hit_next;
    logic res_fill_reg, res_fill_next;
    logic [hbc_pkg::STAT_W-1:0] res_stat_reg, res_stat_next;
    logic out_valid_reg, out_valid_next;
    logic [hbc_pkg::SLOT_W-1:0] out_slot_reg, out_slot_next;
    logic out_hit_reg, out_hit_next;
    logic out_fill_reg, out_fill_next;
    logic [hbc_pkg::STAT_W-1:0] out_stat_reg, out_stat_next;

    logic [FOLD_W-1:0] fold_sum;
    logic [PROD_W-1:0] quot_prod;
    logic [FOLD_W-1:0] rem_full;
    logic [NODE_W-1:0] node_addr;
    logic cur_is_entry;
    logic next_is_head;
    logic [hbc_pkg::CNT_W-1:0] cnt_inc;
    logic [NODE_W-1:0] head_idx;

    assign cur_is_entry = cur_reg < HEAD0;
    assign next_is_head = next_rd >= HEAD0;
    assign cnt_inc = (ent_rd.cnt == hbc_pkg::CNT_MAX) ? ent_rd.cnt
                                                      : ent_rd.cnt + 1'b1;
    assign head_idx = HEAD0 + NODE_W'(mod_reg);
    // bucket index: fold bytes, reciprocal quotient, then remainder
    assign fold_sum = FOLD_W'(blk_reg[7:0]) * W0 + FOLD_W'(blk_reg[15:8]) * W1
                    + FOLD_W'(blk_reg[23:16]) * W2 + FOLD_W'(blk_reg[31:24]) * W3;
    assign quot_prod = PROD_W'(fold_reg) * PROD_W'(RECIP);
    assign rem_full = fold_reg - quot_reg * BKT_MUL;

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        dev_next = dev_reg;
        blk_next = blk_reg;
        fold_next = fold_reg;
        quot_next = quot_reg;
        ent_next = ent_reg;
        mod_next = mod_reg;
        bkt_next = bkt_reg;
        cur_next = cur_reg;
        victim_next = victim_reg;
        res_slot_next = res_slot_reg;
        res_hit_next = res_hit_reg;
        res_fill_next = res_fill_reg;
        res_stat_next = res_stat_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_slot_next = out_slot_reg;
        out_hit_next = out_hit_reg;
        out_fill_next = out_fill_reg;
        out_stat_next = out_stat_reg;
        node_addr = cur_reg;
        ent_raddr = ENT_W'(cur_reg);
        ent_wr = '0;
        ent_waddr = ENT_W'(cur_reg);
        next_we = 1'b0;
        next_waddr = cur_reg;
        next_wdata = cur_reg;
        prev_we = 1'b0;
        prev_waddr = cur_reg;
        prev_wdata = cur_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next = op;
                    dev_next = device;
                    blk_next = block_number;
                    ent_next = entry_index;
                    res_slot_next = entry_index;
                    res_hit_next = 1'b0;
                    res_fill_next = 1'b0;
                    res_stat_next = hbc_pkg::ST_OK;
                    ent_raddr = ENT_W'(entry_index);
                    if (op == hbc_pkg::OP_GET)
                    begin
                        state_next = S_MOD;
                    end
                    else if (32'(entry_index) >= BUFFER_COUNT)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_CNT;
                    end
                end
            end
            S_MOD:
            begin
                fold_next = fold_sum;
                state_next = S_QUOT;
            end
            S_QUOT:
            begin
                quot_next = quot_prod[FOLD_W+RECIP_SH-1:RECIP_SH];
                state_next = S_REM;
            end
            S_REM:
            begin
                mod_next = BKT_W'(rem_full);
                cur_next = HEAD0 + NODE_W'(BKT_W'(rem_full));
                node_addr = cur_next;
                state_next = S_HWALK;
            end
            S_HWALK:
            begin
                if (cur_is_entry && ent_rd.dev == dev_reg && ent_rd.blk == blk_reg)
                begin
                    ent_wr.we = 1'b1;
                    ent_wr.data = '{dev: ent_rd.dev, blk: ent_rd.blk,
                                    cnt: cnt_inc, dval: 1'b1};
                    res_slot_next = hbc_pkg::SLOT_W'(cur_reg);
                    res_hit_next = 1'b1;
                    res_fill_next = !ent_rd.dval;
                    state_next = S_DONE;
                end
                else if (next_is_head)
                begin
                    bkt_next = '0;
                    cur_next = HEAD0;
                    node_addr = HEAD0;
                    state_next = S_SWALK;
                end
                else
                begin
                    cur_next = next_rd;
                    node_addr = next_rd;
                end
            end
            S_SWALK:
            begin
                if (cur_is_entry && ent_rd.cnt == '0)
                begin
                    ent_wr.we = 1'b1;
                    ent_wr.data = '{dev: dev_reg, blk: blk_reg,
                                    cnt: hbc_pkg::CNT_W'(1), dval: 1'b1};
                    res_slot_next = hbc_pkg::SLOT_W'(cur_reg);
                    res_fill_next = 1'b1;
                    victim_next = cur_reg;
                    if (bkt_reg == mod_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // unlink from the old bucket, fetch the target head
                        next_we = 1'b1;
                        next_waddr = prev_rd;
                        next_wdata = next_rd;
                        prev_we = 1'b1;
                        prev_waddr = next_rd;
                        prev_wdata = prev_rd;
                        node_addr = head_idx;
                        state_next = S_PUSH1;
                    end
                end
                else if (next_is_head)
                begin
                    if (bkt_reg == BKT_LAST)
                    begin
                        res_slot_next = '0;
                        res_stat_next = hbc_pkg::ST_NO_BUFFER;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        bkt_next = bkt_reg + 1'b1;
                        cur_next = HEAD0 + NODE_W'(bkt_next);
                        node_addr = cur_next;
                    end
                end
                else
                begin
                    cur_next = next_rd;
                    node_addr = next_rd;
                end
            end
            S_PUSH1:
            begin
                next_we = 1'b1;
                next_waddr = victim_reg;
                next_wdata = next_rd;
                prev_we = 1'b1;
                prev_waddr = next_rd;
                prev_wdata = victim_reg;
                state_next = S_PUSH2;
            end
            S_PUSH2:
            begin
                next_we = 1'b1;
                next_waddr = head_idx;
                next_wdata = victim_reg;
                prev_we = 1'b1;
                prev_waddr = victim_reg;
                prev_wdata = head_idx;
                state_next = S_DONE;
            end
            S_CNT:
            begin
                ent_waddr = ENT_W'(ent_reg);
                ent_wr.data = ent_rd;
                if (op_reg == hbc_pkg::OP_PIN)
                begin
                    ent_wr.we = 1'b1;
                    ent_wr.data.cnt = cnt_inc;
                end
                else if (ent_rd.cnt == '0)
                begin
                    res_stat_next = hbc_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    ent_wr.we = 1'b1;
                    ent_wr.data.cnt = ent_rd.cnt - 1'b1;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_slot_next = res_slot_reg;
                    out_hit_next = res_hit_reg;
                    out_fill_next = res_fill_reg;
                    out_stat_next = res_stat_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        link_raddr = node_addr;
        if (state_reg != S_IDLE && state_reg != S_CNT)
        begin
            ent_raddr = ENT_W'(node_addr);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        dev_reg <= dev_next;
        blk_reg <= blk_next;
        fold_reg <= fold_next;
        quot_reg <= quot_next;
        ent_reg <= ent_next;
        mod_reg <= mod_next;
        bkt_reg <= bkt_next;
        cur_reg <= cur_next;
        victim_reg <= victim_next;
        res_slot_reg <= res_slot_next;
        res_hit_reg <= res_hit_next;
        res_fill_reg <= res_fill_next;
        res_stat_reg <= res_stat_next;
        out_slot_reg <= out_slot_next;
        out_hit_reg <= out_hit_next;
        out_fill_reg <= out_fill_next;
        out_stat_reg <= out_stat_next;
    end

    assign in_ready = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;
    assign buffer_slot = out_slot_reg;
    assign hit = out_hit_reg;
    assign needs_fill = out_fill_reg;
    assign status = out_stat_reg;

endmodule

/* design/hashed_block_buffer_cache.sv */
// channel | signals                                          | handshake
// in      | op, device, block_number, entry_index            | in_valid / in_ready
// out     | buffer_slot, hit, needs_fill, status             | out_valid / out_ready
//
// one transaction at a time; release, pin and unpin update the count in S_CNT (an
// index out of range skips it); a get finds its bucket in S_MOD, S_QUOT and S_REM,
// walks its own bucket (head and entries) one node per cycle, on a miss scans up to
// BUFFER_COUNT + BUCKET_COUNT nodes for a free entry and, if it lies in another
// bucket, relinks it in S_PUSH1 and S_PUSH2; reset is immediate (per-row valid bits).
// results register in S_DONE, held there with in_ready low while a result waits.
// depends on hbc_pkg, hbc_entry_mem, hbc_link_mem, hbc_ctrl
module hashed_block_buffer_cache #(
    parameter int BUFFER_COUNT = hbc_pkg::BUFFER_COUNT_DEF,
    parameter int BUCKET_COUNT = hbc_pkg::BUCKET_COUNT_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [hbc_pkg::OP_W-1:0]   op,
    input  logic [hbc_pkg::DEV_W-1:0]  device,
    input  logic [hbc_pkg::BLK_W-1:0]  block_number,
    input  logic [hbc_pkg::SLOT_W-1:0] entry_index,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [hbc_pkg::SLOT_W-1:0] buffer_slot,
    output logic                       hit,
    output logic                       needs_fill,
    output logic [hbc_pkg::STAT_W-1:0] status
);

    localparam int NODE_W = $clog2(BUFFER_COUNT + BUCKET_COUNT);
    localparam int ENT_W = (BUFFER_COUNT > 1) ? $clog2(BUFFER_COUNT) : 1;

    logic [ENT_W-1:0] ent_raddr;
    logic [ENT_W-1:0] ent_waddr;
    hbc_pkg::entry_t ent_rd;
    hbc_pkg::entry_wr_t ent_wr;
    logic [NODE_W-1:0] link_raddr;
    logic [NODE_W-1:0] next_rd;
    logic [NODE_W-1:0] prev_rd;
    logic next_we;
    logic [NODE_W-1:0] next_waddr;
    logic [NODE_W-1:0] next_wdata;
    logic prev_we;
    logic [NODE_W-1:0] prev_waddr;
    logic [NODE_W-1:0] prev_wdata;

    hbc_entry_mem #(
        .BUFFER_COUNT(BUFFER_COUNT),
        .ENT_W(ENT_W)
    ) u_entry_mem (
        .clk(clk),
        .rst_n(rst_n),
        .raddr(ent_raddr),
        .rdata(ent_rd),
        .wr(ent_wr),
        .waddr(ent_waddr)
    );

    hbc_link_mem #(
        .BUFFER_COUNT(BUFFER_COUNT),
        .BUCKET_COUNT(BUCKET_COUNT),
        .NODE_COUNT(BUFFER_COUNT + BUCKET_COUNT),
        .NODE_W(NODE_W)
    ) u_link_mem (
        .clk(clk),
        .rst_n(rst_n),
        .raddr(link_raddr),
        .next_rd(next_rd),
        .prev_rd(prev_rd),
        .next_we(next_we),
        .next_waddr(next_waddr),
        .next_wdata(next_wdata),
        .prev_we(prev_we),
        .prev_waddr(prev_waddr),
        .prev_wdata(prev_wdata)
    );

    hbc_ctrl #(
        .BUFFER_COUNT(BUFFER_COUNT),
        .BUCKET_COUNT(BUCKET_COUNT),
        .NODE_W(NODE_W),
        .ENT_W(ENT_W)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .op(op),
        .device(device),
        .block_number(block_number),
        .entry_index(entry_index),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .buffer_slot(buffer_slot),
        .hit(hit),
        .needs_fill(needs_fill),
        .status(status),
        .ent_raddr(ent_raddr),
        .ent_rd(ent_rd),
        .ent_wr(ent_wr),
        .ent_waddr(ent_waddr),
        .link_raddr(link_raddr),
        .next_rd(next_rd),
        .prev_rd(prev_rd),
        .next_we(next_we),
        .next_waddr(next_waddr),
        .next_wdata(next_wdata),
        .prev_we(prev_we),
        .prev_waddr(prev_waddr),
        .prev_wdata(prev_wdata)
    );

endmodule

/* tb/hashed_block_buffer_cache_tb.sv */
// testbench for hashed_block_buffer_cache: get, release, pin and unpin traffic
// checked against a behavioral cache model with bucket lists and reference counts
// depends on hbc_pkg and the design under design/
module hashed_block_buffer_cache_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBUF = 32;
    localparam int NBKT = 13;
    localparam int NNODE = NBUF + NBKT;

    typedef struct packed {
        logic [hbc_pkg::SLOT_W-1:0] slot;
        logic                       hit;
        logic                       fill;
        logic [hbc_pkg::STAT_W-1:0] stat;
    } cache_reply_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic [hbc_pkg::OP_W-1:0]   op;
    logic [hbc_pkg::DEV_W-1:0]  device;
    logic [hbc_pkg::BLK_W-1:0]  block_number;
    logic [hbc_pkg::SLOT_W-1:0] entry_index;
    logic                       out_valid;
    logic                       out_ready;
    logic [hbc_pkg::SLOT_W-1:0] buffer_slot;
    logic                       hit;
    logic                       needs_fill;
    logic [hbc_pkg::STAT_W-1:0] status;

    // cache image kept by the testbench
    logic [hbc_pkg::DEV_W-1:0] m_dev [NBUF];
    logic [hbc_pkg::BLK_W-1:0] m_blk [NBUF];
    logic [hbc_pkg::CNT_W-1:0] m_cnt [NBUF];
    logic                      m_val [NBUF];
    int                        m_next [NNODE];
    int                        m_prev [NNODE];

    cache_reply_t pending_replies[$];
    int errors = 0;
    int replies_seen = 0;
    int gets_sent = 0;
    int hits_seen = 0;
    int nobuf_seen = 0;
    logic hold_off = 0;

    hashed_block_buffer_cache dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .op(op), .device(device), .block_number(block_number), .entry_index(entry_index),
        .out_valid(out_valid), .out_ready(out_ready),
        .buffer_slot(buffer_slot), .hit(hit), .needs_fill(needs_fill), .status(status)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("timeout at %0t", $time);
        $display("Some tests failed");
        $finish;
    end

    function automatic void link_unhook(int n);
        m_next[m_prev[n]] = m_next[n];
        m_prev[m_next[n]] = m_prev[n];
    endfunction

    function automatic void link_push(int bkt, int n);
        int h;
        int first;
        h = NBUF + bkt;
        first = m_next[h];
        m_next[n] = first;
        m_prev[n] = h;
        m_prev[first] = n;
        m_next[h] = n;
    endfunction

    function automatic void cache_clear();
        for (int i = 0; i < NBUF; i++)
        begin
            m_dev[i] = '0;
            m_blk[i] = '0;
            m_cnt[i] = '0;
            m_val[i] = 0;
        end
        for (int b = 0; b < NBKT; b++)
        begin
            m_next[NBUF+b] = NBUF + b;
            m_prev[NBUF+b] = NBUF + b;
        end
        for (int i = 0; i < NBUF; i++)
            link_push(0, i);
    endfunction

    function automatic cache_reply_t cache_apply(logic [hbc_pkg::OP_W-1:0] o,
                                                 logic [hbc_pkg::DEV_W-1:0] d,
                                                 logic [hbc_pkg::BLK_W-1:0] b,
                                                 logic [hbc_pkg::SLOT_W-1:0] e);
        cache_reply_t r;
        int home;
        int h;
        int n;
        int steps;
        r = '0;
        if (o == hbc_pkg::OP_GET)
        begin
            home = int'(b % NBKT);
            h = NBUF + home;
            n = m_next[h];
            steps = 0;
            while (n != h && n < NBUF && steps < NBUF)
            begin
                if (m_dev[n] == d && m_blk[n] == b)
                begin
                    r.fill = !m_val[n];
                    if (m_cnt[n] != hbc_pkg::CNT_MAX)
                        m_cnt[n]++;
                    m_val[n] = 1;
                    r.slot = n[hbc_pkg::SLOT_W-1:0];
                    r.hit = 1;
                    return r;
                end
                n = m_next[n];
                steps++;
            end
            for (int k = 0; k < NBKT; k++)
            begin
                h = NBUF + k;
                n = m_next[h];
                steps = 0;
                while (n != h && n < NBUF && steps < NBUF)
                begin
                    if (m_cnt[n] == 0)
                    begin
                        m_cnt[n] = 1;
                        m_dev[n] = d;
                        m_blk[n] = b;
                        m_val[n] = 1;
                        if (k != home)
                        begin
                            link_unhook(n);
                            link_push(home, n);
                        end
                        r.slot = n[hbc_pkg::SLOT_W-1:0];
                        r.fill = 1;
                        return r;
                    end
                    n = m_next[n];
                    steps++;
                end
            end
            r.stat = hbc_pkg::ST_NO_BUFFER;
            return r;
        end
        r.slot = e;
        if (int'(e) >= NBUF)
            return r;
        if (o == hbc_pkg::OP_PIN)
        begin
            if (m_cnt[e] != hbc_pkg::CNT_MAX)
                m_cnt[e]++;
        end
        else if (m_cnt[e] == 0)
            r.stat = hbc_pkg::ST_UNDERFLOW;
        else
            m_cnt[e]--;
        return r;
    endfunction

    // valid stays high from one transaction to the next when there is no gap
    task automatic send_request(logic [hbc_pkg::OP_W-1:0] o, logic [hbc_pkg::DEV_W-1:0] d,
                                logic [hbc_pkg::BLK_W-1:0] b,
                                logic [hbc_pkg::SLOT_W-1:0] e, int gap = -1);
        int g;
        g = gap;
        if (g < 0)
            g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if (g > 0)
        begin
            in_valid <= 0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1;
        op <= o;
        device <= d;
        block_number <= b;
        entry_index <= e;
        do @(posedge clk); while (!in_ready);
        pending_replies.push_back(cache_apply(o, d, b, e));
        if (o == hbc_pkg::OP_GET)
            gets_sent++;
    endtask

    // consumer with random stalls, plus a forced long stall on request
    initial
    begin
        int stall;
        stall = 0;
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
                out_ready <= 0;
            else if (stall > 0)
            begin
                stall--;
                out_ready <= 0;
            end
            else if ($urandom_range(0, 39) == 0)
            begin
                stall = $urandom_range(10, 40);
                out_ready <= 0;
            end
            else
                out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge clk)
    begin
        cache_reply_t want;
        if (rst_n && out_valid && out_ready)
        begin
            replies_seen++;
            if (pending_replies.size() == 0)
            begin
                $display("%0t: unexpected result slot %0d", $time, buffer_slot);
                errors++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (want.hit)
                    hits_seen++;
                if (want.stat == hbc_pkg::ST_NO_BUFFER)
                    nobuf_seen++;
                if (buffer_slot !== want.slot)
                begin
                    $display("%0t: buffer_slot expected %0d actual %0d", $time, want.slot,
                             buffer_slot);
                    errors++;
                end
                if (hit !== want.hit)
                begin
                    $display("%0t: hit expected %0b actual %0b", $time, want.hit, hit);
                    errors++;
                end
                if (needs_fill !== want.fill)
                begin
                    $display("%0t: needs_fill expected %0b actual %0b", $time, want.fill,
                             needs_fill);
                    errors++;
                end
                if (status !== want.stat)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, want.stat, status);
                    errors++;
                end
            end
        end
    end

    task automatic drain_replies();
        in_valid <= 0;
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        // reset tags hit entry 31 with needs_fill set
        send_request(hbc_pkg::OP_GET, '0, '0, '0);
        send_request(hbc_pkg::OP_GET, '0, '0, '0);
        send_request(hbc_pkg::OP_GET, '1, '1, '0);
        send_request(hbc_pkg::OP_GET, 32'h8000_0000, 32'h0000_000D, '0);
        send_request(hbc_pkg::OP_RELEASE, '0, '0, 5'd31);
        send_request(hbc_pkg::OP_RELEASE, '0, '0, 5'd31);
        // underflow on a never-used entry
        send_request(hbc_pkg::OP_RELEASE, '0, '0, 5'd3);
        send_request(hbc_pkg::OP_UNPIN, '0, '0, 5'd4);
        send_request(hbc_pkg::OP_PIN, '1, '1, 5'd4);
        send_request(hbc_pkg::OP_UNPIN, '0, '0, 5'd4);
        // count saturation at the top
        for (int i = 0; i < 64; i++)
            send_request(hbc_pkg::OP_PIN, '0, '0, 5'd7, 0);
        send_request(hbc_pkg::OP_UNPIN, '0, '0, 5'd7);
        drain_replies();
    endtask

    task automatic test_exhaustion();
        logic [hbc_pkg::SLOT_W-1:0] s;
        // pin every entry so no buffer remains free
        for (int i = 0; i < NBUF; i++)
            send_request(hbc_pkg::OP_PIN, '0, '0, i[hbc_pkg::SLOT_W-1:0], 0);
        send_request(hbc_pkg::OP_GET, 32'h1234_5678, 32'h0BAD_F00D, '0);
        send_request(hbc_pkg::OP_GET, '0, 32'hFFFF_FFFE, '0);
        for (int i = 0; i < NBUF; i++)
        begin
            s = i[hbc_pkg::SLOT_W-1:0];
            while (m_cnt[s] != 0)
                send_request(hbc_pkg::OP_RELEASE, '0, '0, s, 0);
        end
        drain_replies();
    endtask

    task automatic test_backpressure();
        // long receiver stall while the sender keeps offering
        fork
            begin
                hold_off = 1;
                repeat (400) @(posedge clk);
                hold_off = 0;
            end
            for (int i = 0; i < 12; i++)
                send_request(hbc_pkg::OP_PIN, '0, '0,
                             hbc_pkg::SLOT_W'($urandom_range(0, 31)), 0);
        join
        drain_replies();
        repeat (50) @(posedge clk);
    endtask

    task automatic test_random_traffic(int count);
        logic [hbc_pkg::DEV_W-1:0] dv;
        logic [hbc_pkg::BLK_W-1:0] bk;
        logic [hbc_pkg::SLOT_W-1:0] ei;
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            ei = hbc_pkg::SLOT_W'($urandom_range(0, 31));
            // small tag pool makes hits and reuse likely
            if ($urandom_range(0, 3) != 0)
            begin
                dv = $urandom_range(0, 3);
                bk = $urandom_range(0, 40);
            end
            else
            begin
                dv = $urandom();
                bk = $urandom();
            end
            if (r < 45)
                send_request(hbc_pkg::OP_GET, dv, bk, ei);
            else if (r < 75)
                send_request(hbc_pkg::OP_RELEASE, $urandom(), $urandom(), ei);
            else if (r < 88)
                send_request(hbc_pkg::OP_PIN, $urandom(), $urandom(), ei);
            else
                send_request(hbc_pkg::OP_UNPIN, $urandom(), $urandom(), ei);
            if (i == count / 2)
                drain_replies();
        end
        drain_replies();
    endtask

    initial
    begin
        rst_n = 0;
        in_valid = 0;
        op = hbc_pkg::OP_GET;
        device = '0;
        block_number = '0;
        entry_index = '0;
        cache_clear();
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        test_directed();
        test_exhaustion();
        test_backpressure();
        test_random_traffic(280);
        repeat (200) @(posedge clk);
        $display("covered %0d results, %0d gets, %0d hits, %0d no-buffer replies",
                 replies_seen, gets_sent, hits_seen, nobuf_seen);
        if (errors == 0 && pending_replies.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
